// ===== src/kernel_correlate_3x3_macros.svh =====
// Assertion macros shared by the 3x3 kernel correlator modules
`ifndef KERNEL_CORRELATE_3X3_MACROS_SVH
`define KERNEL_CORRELATE_3X3_MACROS_SVH

// Same-cycle implication, off while reset is held
`define KC3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define KC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kc3_pkg.sv =====
// Types, sizes and register codes for the 3x3 kernel correlator
package kc3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int TAPS         = 3;
    localparam int PIX_W        = 8;
    localparam int COEF_W       = 16;
    localparam int CFG_W        = TAPS * COEF_W;
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int GEOM_W       = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int IN_ROW_W     = 13;
    localparam int OUT_ROW_W    = 12;
    localparam int PROD_W       = COEF_W + PIX_W;
    localparam int ROW_W        = PROD_W + 2;
    localparam int SUM_W        = 28;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HGT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_KERNEL = 3'd5;

    localparam logic [CFG_W-1:0]    COEF_MID_RESET = 48'h0000_0100_0000;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 13'd1024;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [TAPS-1:0][TAPS-1:0] t_win;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             fill;
    } t_in_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] weighted_sum;
        logic                    frame_last;
    } t_out_word;

    // Per-item position flags: where the result's neighbourhood sits in the frame
    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_pos_flags;

endpackage

// ===== src/kernel_correlate_3x3.sv =====
// Top level of the 3x3 kernel correlator: registers, pipeline and output skid
//
// Input channel: i_valid / o_ready carry one pixel word (pixel, fill) in raster
// order. Output channel: o_valid / i_ready carry one result word (weighted_sum,
// frame_last). The result for a pixel is caused by the word frame_width+1
// positions later; after a frame push frame_width+1 fill words to drain it.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0..2 coefficient rows, 3 width, 4 height, 5 flip); write only while idle.
// Throughput: one word per cycle while o_ready is high. Once the word that
// completes its neighbourhood is taken, the result passes the line store read,
// the window, the multiplier stage, the row adder stage and the output register.
// Reset clears counters, window and pipeline and loads the identity kernel
// scaled by 256 (centre coefficient 256), width 2048, height 1024. Line stores
// are not cleared; unwritten entries only ever feed masked border rows.
// Receiver stall: the output word holds, one more result goes into a skid
// register, and o_ready then falls until the output drains.
`include "kernel_correlate_3x3_macros.svh"
module kernel_correlate_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  kc3_pkg::t_in_word             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output kc3_pkg::t_out_word            o_data,
    input  logic                          i_cfg_we,
    input  logic [kc3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kc3_pkg::CFG_W-1:0]     i_cfg_data
);
    import kc3_pkg::*;

    logic [CFG_W-1:0]    r_coef_top, r_coef_mid, r_coef_bottom;
    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic                r_flip;

    logic                adv, acc, push, take;
    logic [COL_W-1:0]    col;
    t_pos_flags          flags, win_flags;
    t_win                win;
    logic                win_valid, mac_valid;
    t_out_word           mac_word, r_out_word, r_skid_word;
    logic                r_out_valid, r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top     <= '0;
            r_coef_mid     <= COEF_MID_RESET;
            r_coef_bottom  <= '0;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_flip         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_TOP:    r_coef_top     <= i_cfg_data;
                REG_COEF_MID:    r_coef_mid     <= i_cfg_data;
                REG_COEF_BOTTOM: r_coef_bottom  <= i_cfg_data;
                REG_FRAME_WIDTH: r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_FRAME_HGT:   r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_FLIP_KERNEL: r_flip         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the skid register is free
    assign adv     = !r_skid_valid;
    assign acc     = i_valid && adv;
    assign o_ready = adv;

    kc3_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_col          (col),
        .o_flags        (flags)
    );

    kc3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_acc   (acc),
        .i_word  (i_data),
        .i_col   (col),
        .i_flags (flags),
        .o_win   (win),
        .o_valid (win_valid),
        .o_flags (win_flags)
    );

    kc3_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (win_valid),
        .i_flags       (win_flags),
        .i_win         (win),
        .i_coef_top    (r_coef_top),
        .i_coef_mid    (r_coef_mid),
        .i_coef_bottom (r_coef_bottom),
        .i_flip        (r_flip),
        .o_valid       (mac_valid),
        .o_word        (mac_word)
    );

    assign push = adv && mac_valid;
    assign take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_word <= r_skid_word;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out_word <= mac_word;
            end else begin
                r_skid_word <= mac_word;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

    `KC3_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid word held without an output word")
    `KC3_ASSERT_NOW(a_skid_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && !i_ready), "skid filled without a stalled output")

endmodule

// ===== src/kc3_ram.sv =====
// Generic simple dual-port RAM, read-first, registered read
module kc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/kc3_ctrl.sv =====
// Position counters: input column/row, output column/row, border flags
`include "kernel_correlate_3x3_macros.svh"
module kc3_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [kc3_pkg::WIDTH_W-1:0]   i_frame_width,
    input  logic [kc3_pkg::HEIGHT_W-1:0]  i_frame_height,
    output logic [kc3_pkg::COL_W-1:0]     o_col,
    output kc3_pkg::t_pos_flags           o_flags
);
    import kc3_pkg::*;

    logic [GEOM_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [COL_W-1:0]     r_in_col, n_in_col, r_out_col, n_out_col;
    logic [IN_ROW_W-1:0]  r_in_row, n_in_row;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;
    logic                 in_wrap, out_col_end, out_row_end, emit, last;

    // Clamp geometry into the supported range
    always_comb begin
        if (i_frame_width == '0) begin
            w_eff = GEOM_W'(1);
        end else if (GEOM_W'(i_frame_width) > GEOM_W'(MAX_WIDTH)) begin
            w_eff = GEOM_W'(MAX_WIDTH);
        end else begin
            w_eff = GEOM_W'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (i_frame_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = i_frame_height;
        end
    end

    assign in_wrap     = (GEOM_W'(r_in_col) + GEOM_W'(1)) >= w_eff;
    assign out_col_end = (GEOM_W'(r_out_col) + GEOM_W'(1)) >= w_eff;
    assign out_row_end = (HEIGHT_W'(r_out_row) + HEIGHT_W'(1)) >= h_eff;
    assign emit = (r_in_row >= IN_ROW_W'(2))
               || (r_in_row == IN_ROW_W'(1) && r_in_col != '0);
    assign last = emit && out_col_end && out_row_end;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_wrap) begin
            n_in_col = '0;
            n_in_row = r_in_row + IN_ROW_W'(1);
        end else begin
            n_in_col = r_in_col + COL_W'(1);
        end
        if (emit) begin
            if (last) begin
                // frame done: rewind everything for the next frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + OUT_ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_col            = r_in_col;
    assign o_flags.emit     = emit;
    assign o_flags.last     = last;
    assign o_flags.top_ok   = r_out_row != '0;
    assign o_flags.bot_ok   = !out_row_end;
    assign o_flags.left_ok  = r_out_col != '0;
    assign o_flags.right_ok = !out_col_end;

    `KC3_ASSERT_NEXT(a_last_rewinds, i_clk, i_rst_n, i_acc && last, r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0, "frame end did not rewind the counters")
    `KC3_ASSERT_NEXT(a_row_end_wraps, i_clk, i_rst_n, i_acc && emit && out_col_end, r_out_col == '0, "output column did not wrap at row end")

endmodule

// ===== src/kc3_window.sv =====
// Two line stores and the 3x3 neighbourhood window
module kc3_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_acc,
    input  kc3_pkg::t_in_word         i_word,
    input  logic [kc3_pkg::COL_W-1:0] i_col,
    input  kc3_pkg::t_pos_flags       i_flags,
    output kc3_pkg::t_win             o_win,
    output logic                      o_valid,
    output kc3_pkg::t_pos_flags       o_flags
);
    import kc3_pkg::*;

    t_pix             pix_in, lower_rd, upper_rd, top_px;
    logic             r_s1_valid, r_fwd, r_s2_valid;
    logic [COL_W-1:0] r_s1_col;
    t_pix             r_s1_pix, r_fwd_data;
    t_pos_flags       r_s1_flags, r_s2_flags;
    t_win             r_win, n_win;

    assign pix_in = i_word.fill ? '0 : i_word.pixel;

    // Lower store takes the new pixel; the old entry moves up one line
    kc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (i_acc),
        .i_waddr (i_col),
        .i_wdata (pix_in),
        .i_re    (i_adv),
        .i_raddr (i_col),
        .o_rdata (lower_rd)
    );

    kc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_adv && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (lower_rd),
        .i_re    (i_adv),
        .i_raddr (i_col),
        .o_rdata (upper_rd)
    );

    // Upper store is written late, from stage-1 registers; bypass when the next word hits the same column
    assign top_px = r_fwd ? r_fwd_data : upper_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_acc;
            r_fwd      <= i_acc && r_s1_valid && (i_col == r_s1_col);
            r_s2_valid <= r_s1_valid && r_s1_flags.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_col   <= i_col;
            r_s1_pix   <= pix_in;
            r_s1_flags <= i_flags;
            r_fwd_data <= lower_rd;
            r_s2_flags <= r_s1_flags;
        end
    end

    always_comb begin
        for (int r = 0; r < TAPS; r++) begin
            for (int c = 0; c < TAPS - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
        end
        n_win[0][TAPS-1] = top_px;
        n_win[1][TAPS-1] = lower_rd;
        n_win[2][TAPS-1] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_adv && r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_win   = r_win;
    assign o_valid = r_s2_valid;
    assign o_flags = r_s2_flags;

endmodule

// ===== src/kc3_mac.sv =====
// Coefficient select, border masking, nine products and the adder tree
module kc3_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  kc3_pkg::t_pos_flags       i_flags,
    input  kc3_pkg::t_win             i_win,
    input  logic [kc3_pkg::CFG_W-1:0] i_coef_top,
    input  logic [kc3_pkg::CFG_W-1:0] i_coef_mid,
    input  logic [kc3_pkg::CFG_W-1:0] i_coef_bottom,
    input  logic                      i_flip,
    output logic                      o_valid,
    output kc3_pkg::t_out_word        o_word
);
    import kc3_pkg::*;

    logic signed [PROD_W-1:0] n_prod [TAPS][TAPS];
    logic signed [PROD_W-1:0] r_prod [TAPS][TAPS];
    logic signed [ROW_W-1:0]  n_row [TAPS];
    logic signed [ROW_W-1:0]  r_row [TAPS];
    logic                     r_s3_valid, r_s3_last, r_s4_valid, r_s4_last;

    always_comb begin
        logic [1:0]                     kr;
        logic [1:0]                     kc;
        logic [CFG_W-1:0]               coef_row;
        logic signed [COEF_W-1:0]       coef;
        t_pix                           px;
        logic                           keep;
        logic signed [COEF_W+PIX_W:0]   full;
        for (int r = 0; r < TAPS; r++) begin
            for (int c = 0; c < TAPS; c++) begin
                kr = i_flip ? 2'(TAPS - 1 - r) : 2'(r);
                kc = i_flip ? 2'(TAPS - 1 - c) : 2'(c);
                if (kr == 2'd0) begin
                    coef_row = i_coef_top;
                end else if (kr == 2'd1) begin
                    coef_row = i_coef_mid;
                end else begin
                    coef_row = i_coef_bottom;
                end
                coef = coef_row[kc*COEF_W +: COEF_W];
                // drop neighbours outside the frame
                keep = !((r == 0 && !i_flags.top_ok) || (r == TAPS - 1 && !i_flags.bot_ok)
                      || (c == 0 && !i_flags.left_ok) || (c == TAPS - 1 && !i_flags.right_ok));
                px   = keep ? i_win[r][c] : '0;
                full = coef * $signed({1'b0, px});
                n_prod[r][c] = full[PROD_W-1:0];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < TAPS; r++) begin
            n_row[r] = ROW_W'(r_prod[r][0]) + ROW_W'(r_prod[r][1]) + ROW_W'(r_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_adv) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod    <= n_prod;
            r_s3_last <= i_flags.last;
            r_row     <= n_row;
            r_s4_last <= r_s3_last;
        end
    end

    assign o_valid             = r_s4_valid;
    assign o_word.weighted_sum = SUM_W'(r_row[0]) + SUM_W'(r_row[1]) + SUM_W'(r_row[2]);
    assign o_word.frame_last   = r_s4_last;

endmodule

// ===== test/kernel_correlate_3x3_tb.sv =====
// Self-checking testbench for the 3x3 kernel correlator: directed, limit and random frames
`timescale 1ns / 100ps

module kernel_correlate_3x3_tb;
    import kc3_pkg::*;

    localparam int          DRAIN_CYCLES = 8;
    localparam int          END_LIMIT    = 5000;
    localparam int unsigned RANDOM_WORDS = 300;
    localparam int          PART_WORDS   = 24;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_in_word             i_data      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_out_word            o_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Shadow of the block: configuration, line stores, window and position counters
    logic [CFG_W-1:0] coef_row [3] = '{'0, COEF_MID_RESET, '0};
    int unsigned      cfg_width    = WIDTH_RESET;
    int unsigned      cfg_height   = HEIGHT_RESET;
    bit               cfg_flip     = 1'b0;
    logic [7:0]       store_upper [MAX_WIDTH];
    logic [7:0]       store_lower [MAX_WIDTH];
    logic [7:0]       win [3][3]   = '{default: '0};
    int unsigned      in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    t_out_word   pending_results [$];
    t_out_word   want;
    int unsigned failures        = 0;
    int unsigned words_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    bit          tx_idle         = 1'b0;
    bit          rx_idle         = 1'b0;
    int unsigned rx_wait         = 0;

    kernel_correlate_3x3 i_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int unsigned eff_width();
        return (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : (cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_height;
    endfunction

    function automatic bit frame_aligned();
        return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    // Advance the shadow by one word and queue the neighbourhood sum it completes
    task automatic correlate_step(input t_in_word word);
        int unsigned        wd, ht, ic, kr, kc;
        logic [7:0]         v, up, lo;
        bit                 emit, last;
        longint             acc;
        logic signed [15:0] cf;
        t_out_word          res;
        wd  = eff_width();
        ht  = eff_height();
        v   = word.fill ? 8'd0 : word.pixel;
        ic  = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
        up  = store_upper[ic];
        lo  = store_lower[ic];
        store_upper[ic] = lo;
        store_lower[ic] = v;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = v;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= wd) begin
            in_col = 0;
            in_row = (in_row + 1) & 32'h1FFF;
        end else begin
            in_col++;
        end
        if (emit) begin
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    // drop neighbours outside the image
                    if ((r == 0 && out_row < 1) || (r == 2 && out_row + 1 >= ht) ||
                        (c == 0 && out_col < 1) || (c == 2 && out_col + 1 >= wd))
                        continue;
                    kr  = cfg_flip ? 2 - r : r;
                    kc  = cfg_flip ? 2 - c : c;
                    cf  = coef_row[kr][16*kc +: 16];
                    acc += longint'(cf) * longint'(win[r][c]);
                end
            end
            last = (out_col + 1 >= wd) && (out_row + 1 >= ht);
            res.weighted_sum = acc[SUM_W-1:0];
            res.frame_last   = last;
            pending_results.push_back(res);
            if (last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col + 1 >= wd) begin
                out_col = 0;
                out_row = (out_row + 1) & 32'hFFF;
            end else begin
                out_col++;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance, valid still high
    task automatic send_word(input t_in_word word);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        correlate_step(word);
        i_valid <= 1'b1;
        i_data  <= word;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Drained, plus time for words that cause no result to leave the pipeline
    task automatic wait_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_COEF_TOP:    coef_row[0] = val;
            REG_COEF_MID:    coef_row[1] = val;
            REG_COEF_BOTTOM: coef_row[2] = val;
            REG_FRAME_WIDTH: cfg_width   = val[WIDTH_W-1:0];
            REG_FRAME_HGT:   cfg_height  = val[HEIGHT_W-1:0];
            REG_FLIP_KERNEL: cfg_flip    = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_kernel();
        write_reg(REG_COEF_TOP,    {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_COEF_MID,    {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_COEF_BOTTOM, {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_FLIP_KERNEL, CFG_W'($urandom_range(0, 1)));
    endtask

    task automatic set_geometry(input int unsigned wd, input int unsigned ht);
        write_reg(REG_FRAME_WIDTH, CFG_W'(wd));
        write_reg(REG_FRAME_HGT,   CFG_W'(ht));
    endtask

    // One frame of random pixels, then the trailing words
    task automatic send_frame(input int unsigned trail);
        t_in_word word;
        repeat (eff_width() * eff_height()) begin
            word.pixel = 8'($urandom);
            word.fill  = ($urandom_range(0, 15) == 0);
            send_word(word);
        end
        repeat (trail) begin
            word.pixel = 8'($urandom);
            word.fill  = ($urandom_range(0, 7) != 0);
            send_word(word);
        end
    endtask

    // Push words until the position counters are back at a frame start
    task automatic realign();
        int unsigned guard;
        guard = 0;
        while (!frame_aligned() && guard < 20000) begin
            send_word(t_in_word'{8'($urandom), 1'($urandom)});
            guard++;
        end
    endtask

    // Reset kernel is the identity scaled by 256; a fill word inside the frame counts as black
    task automatic test_reset_kernel();
        wait_idle();
        set_geometry(2, 2);
        send_word(t_in_word'{8'h00, 1'b0});
        send_word(t_in_word'{8'hFF, 1'b0});
        send_word(t_in_word'{8'hA5, 1'b1});
        send_word(t_in_word'{8'hFF, 1'b0});
        repeat (3) send_word(t_in_word'{8'h00, 1'b1});
    endtask

    // Most negative sum, flipped kernel, a pixel taken in place of a fill
    task automatic test_extreme_sum();
        wait_idle();
        write_reg(REG_COEF_TOP,    {3{16'h8000}});
        write_reg(REG_COEF_MID,    {3{16'h8000}});
        write_reg(REG_COEF_BOTTOM, {3{16'h8000}});
        write_reg(REG_FLIP_KERNEL, CFG_W'(1));
        set_geometry(3, 3);
        repeat (9) send_word(t_in_word'{8'hFF, 1'b0});
        send_word(t_in_word'{8'h00, 1'b1});
        send_word(t_in_word'{8'h5A, 1'b0});
        send_word(t_in_word'{8'h00, 1'b1});
        send_word(t_in_word'{8'h00, 1'b1});
    endtask

    // Zero width and height act as a single pixel
    task automatic test_degenerate_frame();
        wait_idle();
        write_reg(REG_COEF_MID,    {16'h0000, 16'h7FFF, 16'h0000});
        write_reg(REG_FLIP_KERNEL, CFG_W'(0));
        set_geometry(0, 0);
        send_word(t_in_word'{8'hFF, 1'b0});
        repeat (2) send_word(t_in_word'{8'h00, 1'b1});
    endtask

    // Widest and tallest geometry, including register values beyond the limits;
    // cut each frame short, then shrink the frame and realign
    task automatic test_geometry_limits();
        int unsigned geo_w [4] = '{2048, 4095, 1, 2};
        int unsigned geo_h [4] = '{1, 1, 4096, 8191};
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            load_kernel();
            set_geometry(geo_w[k], geo_h[k]);
            repeat (PART_WORDS) send_word(t_in_word'{8'($urandom), 1'b0});
            wait_idle();
            set_geometry(2, 2);
            realign();
        end
    endtask

    // Shrink the frame while a frame is part way through
    task automatic test_midframe_geometry();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_idle();
        load_kernel();
        set_geometry(6, 5);
        repeat (14) send_word(t_in_word'{8'($urandom), 1'b0});
        wait_idle();
        set_geometry(4, 3);
        realign();
    endtask

    task automatic test_random_frames();
        int unsigned start, wd, ht, trail;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            realign();
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: wd = $urandom_range(1, 4);
                    6, 7, 8:          wd = $urandom_range(5, 12);
                    default:          wd = $urandom_range(13, 32);
                endcase
                ht = (wd > 12) ? $urandom_range(1, 3) : $urandom_range(1, 5);
                if ($urandom_range(0, 19) == 0) wd = 0;
                if ($urandom_range(0, 19) == 0) ht = 0;
                wait_idle();
                set_geometry(wd, ht);
                load_kernel();
            end
            // mostly proper drains; now and then one short or two over
            trail = eff_width() + 1;
            case ($urandom_range(0, 9))
                0:       trail = trail - 1;
                1:       trail = trail + 2;
                default: ;
            endcase
            send_frame(trail);
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    // Receiver: when rx_idle is set, stall a random number of cycles after each word taken
    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: sum %0d last %0b",
                             o_data.weighted_sum, o_data.frame_last);
            end else begin
                want = pending_results.pop_front();
                if (o_data.weighted_sum !== want.weighted_sum ||
                    o_data.frame_last !== want.frame_last) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d: expected sum %0d last %0b, got sum %0d last %0b",
                                 results_checked, want.weighted_sum, want.frame_last,
                                 o_data.weighted_sum, o_data.frame_last);
                end
            end
            results_checked++;
            rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
        end
    end

    initial begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int cycles;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_kernel();
        test_extreme_sum();
        test_degenerate_frame();
        test_geometry_limits();
        test_midframe_geometry();
        test_random_frames();

        i_valid <= 1'b0;
        cycles = 0;
        while (pending_results.size() != 0 && cycles < END_LIMIT) begin
            @(negedge i_clk);
            cycles++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            failures++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Sent %0d pixel words, checked %0d sums, made %0d register writes;",
                 words_sent, results_checked, reg_writes);
        $display("frames from one pixel to 32 wide, limit geometry in cut frames, both kernel modes.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
